FILE: rtl/min_extract_node_list_macros.svh
// assertion helpers for min_extract_node_list
`ifndef MIN_EXTRACT_NODE_LIST_MACROS_SVH
`define MIN_EXTRACT_NODE_LIST_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MEL_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define MEL_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mel_pkg.sv
`default_nettype none

package mel_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 32;
    localparam int ID_BITS  = 16;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = ID_BITS + KEY_BITS;

    // field widths on the ports
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int ID_FIELD_W  = 16;
    localparam int KEY_FIELD_W = 32;
    localparam int CNT_FIELD_W = 7;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 56;
    localparam int M_PAD_W     = M_TDATA_W - ID_FIELD_W - KEY_FIELD_W - CNT_FIELD_W;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POPMIN = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SHIFT,
        S_EMIT
    } t_state;

    // circular slot of an offset from the head, offset below depth
    function automatic t_idx wrap_add(input t_idx base, input t_cnt off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + (IDX_W + 1)'(off);
        if (sum >= (IDX_W + 1)'(DEPTH)) begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    function automatic t_idx wrap_dec(input t_idx base);
        return (base == '0) ? IDX_W'(DEPTH - 1) : base - 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mel_ram.sv
`default_nettype none

module mel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/min_extract_node_list.sv
// min_extract_node_list: bounded list of (node id, key) entries with front push,
// front pop and pop of the first entry holding the smallest key
// input channel s_*: one beat is one request, kind in s_tuser; s_tready is high only
//   while the sequencer is idle, so one request is worked on at a time
// output channel m_*: one beat per request with status, removed entry and fill level
// path from accepted beat to m_tvalid:
//   push, request on empty or full list, unused kind: straight to the emit state
//   pop: scan of the front slot, drain, shift state, emit state
//   pop-min: scan of every held entry, drain, then the entries ahead of the removed
//   one move back in the shift state, then the emit state
// the list sits in a circular buffer (one write, one read port, registered read);
//   the scan reads one slot a cycle through a single key comparator, then the
//   entries ahead of the winner move back one slot a cycle to close the gap
// reset clears head pointer, fill count and handshake state; the buffer itself is
//   not cleared, only slots below the fill count are ever read
// a stalled receiver holds the result beat in the output register; a finished
//   result waits in the sequencer until that register frees up
`default_nettype none
`include "min_extract_node_list_macros.svh"

module min_extract_node_list (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [mel_pkg::S_TDATA_W-1:0]   s_tdata,  // node_id[15:0], key[47:16]
    input  wire logic [mel_pkg::REQ_W-1:0]       s_tuser,  // req_type[1:0]
    // result channel
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [mel_pkg::M_TDATA_W-1:0]   m_tdata,  // out_node_id[15:0],
                                                           // out_key[47:16],
                                                           // entry_count[54:48], zero pad
    output      logic [mel_pkg::STATUS_W-1:0]    m_tuser   // status[1:0]
);

    import mel_pkg::*;

    // control state
    t_state r_state, n_state;
    t_idx   r_head, n_head;        // slot of the front entry
    t_cnt   r_count, n_count;      // entries held
    t_cnt   r_off, n_off;          // scan / shift offset
    t_cnt   r_last, n_last;        // last offset to scan
    logic   r_cmp_vld, n_cmp_vld;  // read data in flight for the comparator
    t_cnt   r_cmp_off, n_cmp_off;
    logic   r_wr_vld, n_wr_vld;    // shift write pending
    t_cnt   r_wr_off, n_wr_off;
    logic   r_out_valid, n_out_valid;

    // payload
    t_cnt                   r_best, n_best;
    logic [ID_BITS-1:0]     r_best_id, n_best_id;
    logic [KEY_BITS-1:0]    r_best_key, n_best_key;
    logic [STATUS_W-1:0]    r_res_status, n_res_status;
    logic [ID_BITS-1:0]     r_res_id, n_res_id;
    logic [KEY_BITS-1:0]    r_res_key, n_res_key;
    logic [STATUS_W-1:0]    r_out_status, n_out_status;
    logic [ID_FIELD_W-1:0]  r_out_id, n_out_id;
    logic [KEY_FIELD_W-1:0] r_out_key, n_out_key;
    logic [CNT_FIELD_W-1:0] r_out_cnt, n_out_cnt;

    // buffer port
    logic               ram_we;
    t_idx               ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;
    logic               ram_re;
    t_idx               ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;
    t_cnt               rd_off;

    logic               s_accept;
    logic [ID_BITS-1:0] rd_id;
    logic [KEY_BITS-1:0] rd_key;
    logic [ID_BITS-1:0] in_id;
    logic [KEY_BITS-1:0] in_key;
    t_idx               head_dec;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (r_state == S_IDLE);

    assign in_id    = ID_BITS'(s_tdata[ID_FIELD_W-1:0]);
    assign in_key   = KEY_BITS'(s_tdata[ID_FIELD_W +: KEY_FIELD_W]);
    assign rd_id    = ram_rdata[ID_BITS-1:0];
    assign rd_key   = ram_rdata[ENT_W-1:ID_BITS];
    assign head_dec = wrap_dec(r_head);

    assign ram_raddr = wrap_add(r_head, rd_off);

    mel_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_last      <= '0;
            r_cmp_vld   <= 1'b0;
            r_cmp_off   <= '0;
            r_wr_vld    <= 1'b0;
            r_wr_off    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_off       <= n_off;
            r_last      <= n_last;
            r_cmp_vld   <= n_cmp_vld;
            r_cmp_off   <= n_cmp_off;
            r_wr_vld    <= n_wr_vld;
            r_wr_off    <= n_wr_off;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best       <= n_best;
        r_best_id    <= n_best_id;
        r_best_key   <= n_best_key;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_key    <= n_res_key;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_key    <= n_out_key;
        r_out_cnt    <= n_out_cnt;
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_off        = r_off;
        n_last       = r_last;
        n_cmp_vld    = 1'b0;
        n_cmp_off    = r_cmp_off;
        n_wr_vld     = 1'b0;
        n_wr_off     = r_wr_off;
        n_out_valid  = r_out_valid && !m_tready;
        n_best       = r_best;
        n_best_id    = r_best_id;
        n_best_key   = r_best_key;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_key    = r_res_key;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_key    = r_out_key;
        n_out_cnt    = r_out_cnt;

        ram_re    = 1'b0;
        rd_off    = r_off;
        ram_we    = r_wr_vld;
        ram_waddr = wrap_add(r_head, r_wr_off);
        ram_wdata = ram_rdata;

        // key comparator: the front entry seeds, later ones win only on strictly less
        if (r_cmp_vld && ((r_cmp_off == '0) || (rd_key < r_best_key))) begin
            n_best     = r_cmp_off;
            n_best_id  = rd_id;
            n_best_key = rd_key;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_res_status = ST_OK;
                    n_res_id     = '0;
                    n_res_key    = '0;
                    n_off        = '0;
                    n_state      = S_EMIT;
                    unique case (s_tuser)
                        REQ_PUSH: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = head_dec;
                                ram_wdata = {in_key, in_id};
                                n_head    = head_dec;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        REQ_POP, REQ_POPMIN: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                                n_last  = (s_tuser == REQ_POP) ? '0 : r_count - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_re    = 1'b1;
                rd_off    = r_off;
                n_cmp_vld = 1'b1;
                n_cmp_off = r_off;
                if (r_off == r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_off = r_off + 1'b1;
                end
            end
            S_DRAIN: begin
                // last compare lands now, shifting starts at the winner
                n_off   = n_best;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_off != '0) begin
                    ram_re   = 1'b1;
                    rd_off   = r_off - 1'b1;
                    n_wr_vld = 1'b1;
                    n_wr_off = r_off;
                    n_off    = r_off - 1'b1;
                end else begin
                    n_head       = wrap_add(r_head, CNT_W'(1));
                    n_count      = r_count - 1'b1;
                    n_res_status = ST_OK;
                    n_res_id     = r_best_id;
                    n_res_key    = r_best_key;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = ID_FIELD_W'(r_res_id);
                    n_out_key    = KEY_FIELD_W'(r_res_key);
                    n_out_cnt    = CNT_FIELD_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_status;
    assign m_tdata  = {{M_PAD_W{1'b0}}, r_out_cnt, r_out_key, r_out_id};

    `MEL_CHECK(a_count_bound, r_count <= CNT_W'(DEPTH), "fill count beyond depth")
    `MEL_CHECK(a_idle_write, (ram_we && r_state == S_IDLE) |-> (s_accept && s_tuser == REQ_PUSH),
        "buffer write in idle without push")
    `MEL_CHECK(a_shift_write, r_wr_vld |-> (r_state == S_SHIFT), "shift write outside shift phase")
    `MEL_CHECK(a_result_src, $rose(m_tvalid) |-> $past(r_state == S_EMIT),
        "result beat not from emit")
    `MEL_CHECK_NEXT(a_push_count,
        s_accept && s_tuser == REQ_PUSH && r_count != CNT_W'(DEPTH),
        r_count == $past(r_count) + 1'b1, "push did not grow the list")

endmodule

`default_nettype wire

FILE: tb/sv/min_extract_node_list_checker.sv
`default_nettype none

module min_extract_node_list_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [mel_pkg::S_TDATA_W-1:0]   i_s_tdata,  // node_id[15:0], key[47:16]
    input  wire logic [mel_pkg::REQ_W-1:0]       i_s_tuser,  // req_type[1:0]
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [mel_pkg::M_TDATA_W-1:0]   i_m_tdata,  // out_node_id[15:0],
                                                             // out_key[47:16],
                                                             // entry_count[54:48], zero pad
    input  wire logic [mel_pkg::STATUS_W-1:0]    i_m_tuser,  // status[1:0]
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mel_pkg::*;

    typedef struct packed {
        logic [ID_BITS-1:0]  node_id;
        logic [KEY_BITS-1:0] dist_key;
    } node_entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_FIELD_W-1:0]  node_id;
        logic [KEY_FIELD_W-1:0] dist_key;
        logic [CNT_FIELD_W-1:0] count;
        logic [M_PAD_W-1:0]     pad;
    } list_result_t;

    node_entry_t  held_entries[$];
    list_result_t awaited_results[$];

    // apply one request to the modelled list and give the result it should produce
    function automatic list_result_t apply_request(input logic [REQ_W-1:0] req,
                                                   input logic [ID_FIELD_W-1:0] id,
                                                   input logic [KEY_FIELD_W-1:0] k);
        list_result_t res;
        node_entry_t  ent;
        int           best;
        int           i;
        res = '0;
        best = 0;
        case (req)
            REQ_PUSH: begin
                if (held_entries.size() >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    ent.node_id  = id[ID_BITS-1:0];
                    ent.dist_key = k[KEY_BITS-1:0];
                    held_entries.push_front(ent);
                end
            end
            REQ_POP, REQ_POPMIN: begin
                if (held_entries.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // first strictly smallest key wins, so ties go to the front
                    if (req == REQ_POPMIN) begin
                        for (i = 1; i < held_entries.size(); i++) begin
                            if (held_entries[i].dist_key < held_entries[best].dist_key) begin
                                best = i;
                            end
                        end
                    end
                    res.node_id  = ID_FIELD_W'(held_entries[best].node_id);
                    res.dist_key = KEY_FIELD_W'(held_entries[best].dist_key);
                    held_entries.delete(best);
                end
            end
            default: begin
                // unused kind leaves the list alone
            end
        endcase
        res.count = CNT_FIELD_W'(held_entries.size());
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        list_result_t seen;
        list_result_t want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                awaited_results.push_back(apply_request(i_s_tuser,
                                                        i_s_tdata[ID_FIELD_W-1:0],
                                                        i_s_tdata[S_TDATA_W-1:ID_FIELD_W]));
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.status   = i_m_tuser;
                seen.node_id  = i_m_tdata[ID_FIELD_W-1:0];
                seen.dist_key = i_m_tdata[ID_FIELD_W+KEY_FIELD_W-1:ID_FIELD_W];
                seen.count    = i_m_tdata[ID_FIELD_W+KEY_FIELD_W+CNT_FIELD_W-1:
                                          ID_FIELD_W+KEY_FIELD_W];
                seen.pad      = i_m_tdata[M_TDATA_W-1:M_TDATA_W-M_PAD_W];
                if (awaited_results.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected beat: status %0d id %h key %h count %0d",
                                 $realtime, seen.status, seen.node_id, seen.dist_key,
                                 seen.count);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status || seen.node_id !== want.node_id ||
                        seen.dist_key !== want.dist_key || seen.count !== want.count ||
                        seen.pad !== want.pad) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("%0t: exp/act st %0d/%0d id %h/%h key %h/%h cnt %0d/%0d",
                                     $realtime, want.status, seen.status, want.node_id,
                                     seen.node_id, want.dist_key, seen.dist_key,
                                     want.count, seen.count);
                            $display("    pad %b/%b", want.pad, seen.pad);
                        end
                    end
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mel_pkg::*;

    // request code the block answers without touching the list
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // random requests to send after the directed part
    localparam int RANDOM_ITEMS = 400;

    // quiet time after the last result, a little over the longest pop-min
    localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    wire logic              s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;   // node_id[15:0], key[47:16]
    logic [REQ_W-1:0]       s_tuser = '0;   // req_type[1:0]
    wire logic              m_tvalid;
    logic                   m_tready = 1'b0;
    wire logic [M_TDATA_W-1:0] m_tdata;     // out_node_id[15:0], out_key[47:16],
                                            // entry_count[54:48], zero pad
    wire logic [STATUS_W-1:0]  m_tuser;     // status[1:0]

    int  fail_count;
    int  pending;
    int  ready_hold = 0;
    bit  steady = 1'b0;       // no gaps and no new receiver stalls while set
    int  sent = 0;            // random requests that the block acts on

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    min_extract_node_list dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    min_extract_node_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver back-pressure: mostly ready, short stalls common, long ones rare
    always @(posedge i_clk) begin : ready_drive
        int r;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 20);
            end else if (r < 90) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else if (r < 97) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(3, 10);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(20, 60);
            end
        end
    end

    // keys: a narrow band to force ties, the extremes, or anything
    function automatic logic [KEY_FIELD_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return KEY_FIELD_W'($urandom_range(0, 3));
        end else if (r == 4) begin
            return '0;
        end else if (r == 5) begin
            return '1;
        end
        return KEY_FIELD_W'($urandom);
    endfunction

    // present one request beat, hold it until taken, then maybe leave a gap
    task automatic send_req(input logic [REQ_W-1:0] req,
                            input logic [ID_FIELD_W-1:0] id,
                            input logic [KEY_FIELD_W-1:0] k);
        int gap;
        int r;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {k, id};
        do @(posedge i_clk); while (!s_tready);
        if (req != REQ_UNUSED) begin
            sent = sent + 1;
        end
        gap = 0;
        if (!steady) begin
            r = $urandom_range(0, 99);
            if (r >= 97) begin
                gap = $urandom_range(30, 100);
            end else if (r >= 85) begin
                gap = $urandom_range(4, 12);
            end else if (r >= 50) begin
                gap = $urandom_range(1, 3);
            end
        end
        // only drop valid when a gap follows, so a back-to-back beat keeps it high
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {KEY_FIELD_W'($urandom), ID_FIELD_W'($urandom)};
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one request of a random kind, push share in percent
    task automatic send_random(input int push_pct);
        int r;
        logic [REQ_W-1:0] req;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            req = REQ_UNUSED;
        end else if (r < 3 + push_pct * 97 / 100) begin
            req = REQ_PUSH;
        end else if ($urandom_range(0, 2) == 0) begin
            req = REQ_POP;
        end else begin
            req = REQ_POPMIN;
        end
        send_req(req, ID_FIELD_W'($urandom), pick_key());
    endtask

    initial begin : stimulus
        int seg;
        int len;
        int pct;
        bit paused;
        paused = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list pops, unused kind, field extremes, ties, single entry
        send_req(REQ_POP, '1, '1);
        send_req(REQ_POPMIN, '1, '1);
        send_req(REQ_UNUSED, '1, '1);
        send_req(REQ_PUSH, '0, '0);
        send_req(REQ_POPMIN, '1, '1);          // single entry goes
        send_req(REQ_PUSH, '1, '1);
        send_req(REQ_POP, '0, '0);
        send_req(REQ_PUSH, 16'h000a, 32'd5);
        send_req(REQ_PUSH, 16'h000b, 32'd5);
        send_req(REQ_PUSH, 16'h000c, 32'd7);
        send_req(REQ_UNUSED, 16'h5a5a, 32'ha5a5_a5a5);
        send_req(REQ_POPMIN, '0, '0);          // tie on 5: nearer the front wins
        send_req(REQ_POPMIN, '0, '0);
        send_req(REQ_PUSH, 16'hffff, 32'hffff_ffff);
        send_req(REQ_PUSH, 16'h8000, 32'h0000_0000);
        send_req(REQ_PUSH, 16'h0001, 32'hffff_fffe);
        send_req(REQ_POPMIN, '0, '0);          // smallest sits in the middle
        send_req(REQ_POPMIN, '0, '0);
        send_req(REQ_POP, '0, '0);
        send_req(REQ_POP, '0, '0);
        send_req(REQ_POPMIN, '0, '0);          // empty again
        sent = 0;

        // overfill so that pushes to a full list get dropped, then drain past empty
        repeat (DEPTH + 6) send_random(100);
        repeat (DEPTH + 6) send_random(0);

        while (sent < RANDOM_ITEMS) begin
            seg = $urandom_range(0, 9);
            len = $urandom_range(5, 30);
            steady = (seg == 9);
            if (seg < 4) begin
                pct = 70;
            end else if (seg < 7) begin
                pct = 25;
            end else begin
                pct = 50;
            end
            repeat (len) send_random(pct);
            steady = 1'b0;
            // hold the sender off until the block has answered everything
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
                repeat (DRAIN_CYCLES) @(posedge i_clk);
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("min_extract_node_list verification clean");
        end else begin
            $display("min_extract_node_list verification failed");
        end
        $finish;
    end

    // hang guard, many times the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("min_extract_node_list verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/mel_pkg.sv
rtl/mel_ram.sv
rtl/min_extract_node_list.sv
tb/sv/min_extract_node_list_checker.sv
tb/sv/tb_top.sv
